[design/ctsbc_pkg.sv]
// ----------------------------------------------------------------------------
// Circle table segment check package
// Shared types, codes and default sizes for the circle table segment check.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsbc_pkg;

    localparam int DEFAULT_MAX_ISLANDS = 16;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BLOCKED = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_BAD_IDX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DONE
    } state_t;

    // One stored circle.
    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [15:0]        radius;
        logic [1:0]         source;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    clr_count;
        logic    wr_en;
        logic    rd_en;
        logic    rd_walk;
        logic    q_start;
        logic    out_load;
        status_t status;
        logic    show_entry;
        logic    show_hit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic bad_index;
        logic hit;
        logic busy;
    } stat_t;

endpackage

`default_nettype wire

[design/ctsbc_dpath.sv]
// ----------------------------------------------------------------------------
// Circle table segment check datapath
// Holds the circle table, the clearance register, the pipelined distance
// test and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsbc_dpath
    import ctsbc_pkg::*;
#(
    parameter int MAX_ISLANDS = DEFAULT_MAX_ISLANDS,
    parameter int AW = (MAX_ISLANDS > 1) ? $clog2(MAX_ISLANDS) : 1,
    parameter int CW = $clog2(MAX_ISLANDS + 1)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    input  wire logic [AW-1:0]      walk_addr,
    output stat_t                   stat,
    output logic [CW-1:0]           count,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [15:0]        cfg_data,
    input  wire logic signed [19:0] pos_x,
    input  wire logic signed [19:0] pos_y,
    input  wire logic signed [19:0] end_x,
    input  wire logic signed [19:0] end_y,
    input  wire logic [15:0]        radius,
    input  wire logic [1:0]         source,
    input  wire logic [3:0]         index,
    output logic [1:0]              status,
    output logic [3:0]              hit_index,
    output logic [4:0]              entry_count,
    output logic signed [19:0]      entry_x,
    output logic signed [19:0]      entry_y,
    output logic [15:0]             entry_radius,
    output logic [1:0]              entry_source
);

    localparam int NSTG = 7;

    entry_t mem [MAX_ISLANDS];
    entry_t rd_data_reg;

    logic [CW-1:0]      count_reg;
    logic [15:0]        clearance_reg;
    logic signed [19:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [15:0]        rad_in_reg;
    logic [1:0]         src_in_reg;
    logic [3:0]         index_reg;
    logic signed [20:0] dx_reg, dy_reg;
    logic signed [41:0] dxdx_reg, dydy_reg;
    logic [42:0]        len2_reg;

    logic [NSTG-1:0]    v_reg;
    logic [AW-1:0]      i_reg [NSTG];
    logic [AW-1:0]      rd_addr;

    // Stage 1
    logic signed [20:0] ex1_reg, ey1_reg, fx1_reg, fy1_reg;
    logic [16:0]        lim1_reg;
    // Stage 2
    logic signed [41:0] exex2_reg, eyey2_reg, exdx2_reg, eydy2_reg;
    logic signed [41:0] exdy2_reg, eydx2_reg, fxfx2_reg, fyfy2_reg;
    logic [33:0]        lim2_2_reg;
    // Stage 3
    logic [42:0]        dstart3_reg, dend3_reg;
    logic signed [42:0] dot3_reg, crs3_reg;
    logic [33:0]        lim2_3_reg;
    // Stage 4
    logic [42:0]        crs_mag;
    logic [41:0]        chh4_reg, chl4_reg, cll4_reg;
    logic [38:0]        phh4_reg, phl4_reg, plh4_reg, pll4_reg;
    logic               near4_reg, past4_reg, sclose4_reg, eclose4_reg;
    // Stage 5
    logic [83:0]        crs2_5_reg, prod5_reg;
    logic               near5_reg, past5_reg, sclose5_reg, eclose5_reg;
    // Stage 6
    logic               close6_reg;

    logic               hit_reg;
    logic [AW-1:0]      hit_idx_reg;

    status_t            status_reg;
    logic [3:0]         hit_index_reg;
    logic [4:0]         entry_count_reg;
    entry_t             out_entry_reg;

    // Configuration and table count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearance_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                clearance_reg <= cfg_data;
            end
            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // Item fields and per-query segment terms.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg     <= pos_x;
            ay_reg     <= pos_y;
            bx_reg     <= end_x;
            by_reg     <= end_y;
            rad_in_reg <= radius;
            src_in_reg <= source;
            index_reg  <= index;
        end
        // These are registered in turn after a load and settle before the walk needs them.
        dx_reg   <= {bx_reg[19], bx_reg} - {ax_reg[19], ax_reg};
        dy_reg   <= {by_reg[19], by_reg} - {ay_reg[19], ay_reg};
        dxdx_reg <= dx_reg * dx_reg;
        dydy_reg <= dy_reg * dy_reg;
        len2_reg <= {1'b0, dxdx_reg} + {1'b0, dydy_reg};
    end

    assign rd_addr = cmd.rd_walk ? walk_addr : AW'(index_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[AW'(count_reg)] <= '{x: ax_reg, y: ay_reg, radius: rad_in_reg,
                                     source: src_in_reg};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits of the test pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg       <= '0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
        end
        else if (cmd.q_start)
        begin
            v_reg       <= '0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[NSTG-2:0], cmd.rd_en & cmd.rd_walk};
            // Entries leave the pipeline in index order, so the first hit
            // seen here is the lowest blocking index.
            if (v_reg[NSTG-1] && close6_reg && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= i_reg[NSTG-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg[0] <= rd_addr;
        for (int s = 1; s < NSTG; s++)
        begin
            i_reg[s] <= i_reg[s-1];
        end
    end

    assign crs_mag = crs3_reg[42] ? 43'(-crs3_reg) : 43'(crs3_reg);

    always_ff @(posedge clk)
    begin
        // Stage 1: offsets from both end points and the limit.
        ex1_reg  <= {rd_data_reg.x[19], rd_data_reg.x} - {ax_reg[19], ax_reg};
        ey1_reg  <= {rd_data_reg.y[19], rd_data_reg.y} - {ay_reg[19], ay_reg};
        fx1_reg  <= {rd_data_reg.x[19], rd_data_reg.x} - {bx_reg[19], bx_reg};
        fy1_reg  <= {rd_data_reg.y[19], rd_data_reg.y} - {by_reg[19], by_reg};
        lim1_reg <= {1'b0, rd_data_reg.radius} + {1'b0, clearance_reg};

        // Stage 2: products.
        exex2_reg  <= ex1_reg * ex1_reg;
        eyey2_reg  <= ey1_reg * ey1_reg;
        exdx2_reg  <= ex1_reg * dx_reg;
        eydy2_reg  <= ey1_reg * dy_reg;
        exdy2_reg  <= ex1_reg * dy_reg;
        eydx2_reg  <= ey1_reg * dx_reg;
        fxfx2_reg  <= fx1_reg * fx1_reg;
        fyfy2_reg  <= fy1_reg * fy1_reg;
        lim2_2_reg <= lim1_reg * lim1_reg;

        // Stage 3: distances, projection and cross product.
        dstart3_reg <= {1'b0, exex2_reg} + {1'b0, eyey2_reg};
        dend3_reg   <= {1'b0, fxfx2_reg} + {1'b0, fyfy2_reg};
        dot3_reg    <= {exdx2_reg[41], exdx2_reg} + {eydy2_reg[41], eydy2_reg};
        crs3_reg    <= {exdy2_reg[41], exdy2_reg} - {eydx2_reg[41], eydx2_reg};
        lim2_3_reg  <= lim2_2_reg;

        // Stage 4: partial products of cross squared and limit squared
        // times length squared, plus the end point decisions.
        chh4_reg    <= crs_mag[41:21] * crs_mag[41:21];
        chl4_reg    <= crs_mag[41:21] * crs_mag[20:0];
        cll4_reg    <= crs_mag[20:0] * crs_mag[20:0];
        phh4_reg    <= lim2_3_reg[33:17] * len2_reg[42:21];
        phl4_reg    <= lim2_3_reg[33:17] * len2_reg[20:0];
        plh4_reg    <= lim2_3_reg[16:0] * len2_reg[42:21];
        pll4_reg    <= lim2_3_reg[16:0] * len2_reg[20:0];
        near4_reg   <= (len2_reg == '0) || (dot3_reg <= 43'sd0);
        past4_reg   <= $signed({dot3_reg[42], dot3_reg}) >= $signed({1'b0, len2_reg});
        sclose4_reg <= dstart3_reg < {9'b0, lim2_3_reg};
        eclose4_reg <= dend3_reg < {9'b0, lim2_3_reg};

        // Stage 5: sum the partial products.
        crs2_5_reg  <= (84'(chh4_reg) << 42) + (84'(chl4_reg) << 22) + 84'(cll4_reg);
        prod5_reg   <= (84'(phh4_reg) << 38) + (84'(phl4_reg) << 17)
                     + (84'(plh4_reg) << 21) + 84'(pll4_reg);
        near5_reg   <= near4_reg;
        past5_reg   <= past4_reg;
        sclose5_reg <= sclose4_reg;
        eclose5_reg <= eclose4_reg;

        // Stage 6: pick the test that applies.
        if (near5_reg)
        begin
            close6_reg <= sclose5_reg;
        end
        else if (past5_reg)
        begin
            close6_reg <= eclose5_reg;
        end
        else
        begin
            close6_reg <= crs2_5_reg < prod5_reg;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg      <= cmd.status;
            hit_index_reg   <= cmd.show_hit ? 4'(hit_idx_reg) : 4'd0;
            entry_count_reg <= 5'(count_reg);
            out_entry_reg   <= cmd.show_entry ? rd_data_reg : '0;
        end
    end

    assign stat.full      = count_reg >= CW'(MAX_ISLANDS);
    assign stat.bad_index = 32'(index_reg) >= 32'(count_reg);
    assign stat.hit       = hit_reg;
    assign stat.busy      = |v_reg;
    assign count          = count_reg;

    assign status       = status_reg;
    assign hit_index    = hit_index_reg;
    assign entry_count  = entry_count_reg;
    assign entry_x      = out_entry_reg.x;
    assign entry_y      = out_entry_reg.y;
    assign entry_radius = out_entry_reg.radius;
    assign entry_source = out_entry_reg.source;

endmodule

`default_nettype wire

[design/ctsbc_ctrl.sv]
// ----------------------------------------------------------------------------
// Circle table segment check controller
// Sequences each item: accept, execute or walk the table, deliver result.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsbc_ctrl
    import ctsbc_pkg::*;
#(
    parameter int MAX_ISLANDS = DEFAULT_MAX_ISLANDS,
    parameter int AW = (MAX_ISLANDS > 1) ? $clog2(MAX_ISLANDS) : 1,
    parameter int CW = $clog2(MAX_ISLANDS + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    mode,
    output logic               out_valid,
    input  wire logic          out_stall,
    output cmd_t               cmd,
    output logic [AW-1:0]      walk_addr,
    input  wire stat_t         stat,
    input  wire logic [CW-1:0] count
);

    state_t        state_reg, state_next;
    mode_t         mode_reg;
    logic [CW-1:0] walk_idx_reg, walk_idx_next;
    status_t       status_reg, status_next;
    logic          show_entry_reg, show_entry_next;
    logic          show_hit_reg, show_hit_next;
    logic          out_valid_reg, out_valid_next;
    logic          accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign walk_addr = AW'(walk_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_CLEAR;
            walk_idx_reg   <= '0;
            status_reg     <= STAT_OK;
            show_entry_reg <= 1'b0;
            show_hit_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (accept)
            begin
                mode_reg <= mode_t'(mode);
            end
            walk_idx_reg   <= walk_idx_next;
            status_reg     <= status_next;
            show_entry_reg <= show_entry_next;
            show_hit_reg   <= show_hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        walk_idx_next   = walk_idx_reg;
        status_next     = status_reg;
        show_entry_next = show_entry_reg;
        show_hit_next   = show_hit_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cmd             = '0;
        cmd.status      = status_reg;
        cmd.show_entry  = show_entry_reg;
        cmd.show_hit    = show_hit_reg;
        cmd.load        = accept;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                show_entry_next = 1'b0;
                show_hit_next   = 1'b0;
                status_next     = STAT_OK;
                state_next      = ST_DONE;
                case (mode_reg)
                    MODE_CLEAR:
                    begin
                        cmd.clr_count = 1'b1;
                    end
                    MODE_ADD:
                    begin
                        if (stat.full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            cmd.wr_en = 1'b1;
                        end
                    end
                    MODE_READ:
                    begin
                        cmd.rd_en = 1'b1;
                        if (stat.bad_index)
                        begin
                            status_next = STAT_BAD_IDX;
                        end
                        else
                        begin
                            show_entry_next = 1'b1;
                        end
                    end
                    MODE_QUERY:
                    begin
                        cmd.q_start   = 1'b1;
                        walk_idx_next = '0;
                        state_next    = ST_WALK;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WALK:
            begin
                cmd.rd_walk = 1'b1;
                if (stat.hit)
                begin
                    status_next   = STAT_BLOCKED;
                    show_hit_next = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (walk_idx_reg < count)
                begin
                    cmd.rd_en     = 1'b1;
                    walk_idx_next = walk_idx_reg + CW'(1);
                end
                else if (!stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A walk read never goes past the filled part of the table.
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en && cmd.rd_walk) |-> (walk_idx_reg < count))
        else $error("walk read beyond entry count");

    // A clean walk ends only after every entry was issued.
    a_walk_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && state_next == ST_DONE && !stat.hit)
        |-> (walk_idx_reg == count))
        else $error("walk ended before all entries were tested");

    // Nothing is stored into a full table.
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !stat.full)
        else $error("write into full table");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[design/circle_table_segment_block_check_unit.sv]
// ----------------------------------------------------------------------------
// Circle table segment check
// Table of circular obstacles with clear, add, read and segment queries.
// ----------------------------------------------------------------------------
// Clear, add and read items pass from the accepting beat through an execute
// state to a done state, which loads the result into the output register once
// that is free. A query also walks the table in between; one that finds a
// blocking circle can end sooner than one in which no circle blocks. The
// controller reads one stored circle per cycle from the table memory into a
// seven stage distance pipeline. The query ends when the first blocking
// circle leaves the pipeline or the last one has been tested. A new item is
// accepted once the previous result sits in the output register, even if
// that beat is still stalled. The clearance register may be written only
// while the block is idle.
`default_nettype none

module circle_table_segment_block_check_unit
    import ctsbc_pkg::*;
#(
    parameter int MAX_ISLANDS = DEFAULT_MAX_ISLANDS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         mode,
    input  wire logic signed [19:0] pos_x,
    input  wire logic signed [19:0] pos_y,
    input  wire logic signed [19:0] end_x,
    input  wire logic signed [19:0] end_y,
    input  wire logic [15:0]        radius,
    input  wire logic [1:0]         source,
    input  wire logic [3:0]         index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [3:0]              hit_index,
    output logic [4:0]              entry_count,
    output logic signed [19:0]      entry_x,
    output logic signed [19:0]      entry_y,
    output logic [15:0]             entry_radius,
    output logic [1:0]              entry_source,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data
);

    localparam int AW = (MAX_ISLANDS > 1) ? $clog2(MAX_ISLANDS) : 1;
    localparam int CW = $clog2(MAX_ISLANDS + 1);

    cmd_t          cmd;
    stat_t         stat;
    logic [AW-1:0] walk_addr;
    logic [CW-1:0] count;

    assign cfg_ready = 1'b1;

    ctsbc_ctrl #(
        .MAX_ISLANDS (MAX_ISLANDS),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .walk_addr (walk_addr),
        .stat      (stat),
        .count     (count)
    );

    ctsbc_dpath #(
        .MAX_ISLANDS (MAX_ISLANDS),
        .AW          (AW),
        .CW          (CW)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .walk_addr    (walk_addr),
        .stat         (stat),
        .count        (count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .radius       (radius),
        .source       (source),
        .index        (index),
        .status       (status),
        .hit_index    (hit_index),
        .entry_count  (entry_count),
        .entry_x      (entry_x),
        .entry_y      (entry_y),
        .entry_radius (entry_radius),
        .entry_source (entry_source)
    );

endmodule

`default_nettype wire
